// File: hdl/ion_chromatogram_extract_integrate_macros.svh
// Assertion helpers for the checker file icei_checker.sv.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ION_CHROMATOGRAM_EXTRACT_INTEGRATE_MACROS_SVH
`define ION_CHROMATOGRAM_EXTRACT_INTEGRATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ICEI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ICEI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/icei_pkg.sv
package icei_pkg;

  // Field widths.
  localparam int MzW    = 32;
  localparam int RtW    = 27;
  localparam int IntW   = 32;
  localparam int TolW   = 9;
  localparam int AreaW  = 64;
  localparam int ScaleW = 24;

  // Derived widths of the window test and the trapezoid term.
  localparam int LhsW  = MzW + ScaleW;
  localparam int RhsW  = MzW + TolW;
  localparam int SumW  = IntW + 1;
  localparam int TermW = SumW + RtW;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  // One ppm tenth is 1e-7 of the target.
  localparam logic [ScaleW-1:0] TenthPpmScale = 24'd10000000;

  // Register reset values.
  localparam logic [MzW-1:0]  TargetReset   = '0;
  localparam logic [TolW-1:0] TolReset      = 9'd50;
  localparam logic [RtW-1:0]  RtStartReset  = '0;
  localparam logic [RtW-1:0]  RtEndReset    = 27'd86400000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_MZ = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_RT_START  = 2'd2,
    CFG_RT_END    = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    KIND_POINT   = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic [MzW-1:0]  target_mz;
    logic [TolW-1:0] tolerance;
    logic [RtW-1:0]  rt_start;
    logic [RtW-1:0]  rt_end;
  } cfg_t;

  // Request as taken from the input channel.
  typedef struct packed {
    logic            mode;
    logic [RtW-1:0]  t;
    logic [MzW-1:0]  mz;
    logic [IntW-1:0] inten;
    logic            has_peak;
    logic            last;
  } item_t;

  // Request after the window products are formed.
  typedef struct packed {
    logic            mode;
    logic [RtW-1:0]  t;
    logic [IntW-1:0] inten;
    logic            has_peak;
    logic            last;
    logic            rt_in;
    logic [LhsW-1:0] lhs;
    logic [RhsW-1:0] rhs;
  } match_t;

  // Emitted point or summary, area term still as factors.
  typedef struct packed {
    kind_t           kind;
    logic [RtW-1:0]  rt;
    logic [IntW-1:0] point;
    logic [IntW-1:0] best_int;
    logic [RtW-1:0]  best_rt;
    logic [SumW-1:0] sum;
    logic [RtW-1:0]  dt;
  } point_t;

  // Same, with the area term multiplied out.
  typedef struct packed {
    kind_t            kind;
    logic [RtW-1:0]   rt;
    logic [IntW-1:0]  point;
    logic [IntW-1:0]  best_int;
    logic [RtW-1:0]   best_rt;
    logic [TermW-1:0] term;
  } term_t;

  typedef struct packed {
    kind_t            kind;
    logic [RtW-1:0]   rt;
    logic [IntW-1:0]  point;
    logic [IntW-1:0]  best_int;
    logic [RtW-1:0]   best_rt;
    logic [AreaW-1:0] area;
  } result_t;

endpackage

// File: hdl/icei_if.sv
// Input channel: one centroid peak, empty-scan marker or end-of-run request.
interface icei_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [icei_pkg::RtW-1:0]   scan_time_ms;
  logic [icei_pkg::MzW-1:0]   peak_mz;
  logic [icei_pkg::IntW-1:0]  peak_intensity;
  logic                       has_peak;
  logic                       last_in_scan;

  modport source (
    output valid, mode, scan_time_ms, peak_mz, peak_intensity, has_peak, last_in_scan,
    input  ready
  );
  modport sink (
    input  valid, mode, scan_time_ms, peak_mz, peak_intensity, has_peak, last_in_scan,
    output ready
  );
endinterface

// Result channel: chromatogram point or run summary.
interface icei_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [icei_pkg::RtW-1:0]   point_rt_ms;
  logic [icei_pkg::IntW-1:0]  point_intensity;
  logic [icei_pkg::IntW-1:0]  peak_max_intensity;
  logic [icei_pkg::RtW-1:0]   peak_rt_ms;
  logic [icei_pkg::AreaW-1:0] area_scaled;

  modport source (
    output valid, kind, point_rt_ms, point_intensity, peak_max_intensity, peak_rt_ms,
           area_scaled,
    input  ready
  );
  modport sink (
    input  valid, kind, point_rt_ms, point_intensity, peak_max_intensity, peak_rt_ms,
           area_scaled,
    output ready
  );
endinterface

// File: hdl/icei_match.sv
// Input register, then the m/z window products and the retention window test.
module icei_match (
  input  logic                clk,
  input  logic                rst_n,
  input  icei_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  icei_pkg::item_t     in_item,
  output logic                m_valid,
  input  logic                m_ready,
  output icei_pkg::match_t    m_out
);

  logic                          v1_r;
  logic                          v2_r;
  icei_pkg::item_t               item_r;
  icei_pkg::match_t              m_r;
  icei_pkg::match_t              m_nxt;
  logic                          s1_ld;
  logic                          s2_ld;
  logic [icei_pkg::MzW-1:0]      diff;

  // A stage loads when it is empty or its content moves on.
  assign s2_ld    = !v2_r || m_ready;
  assign s1_ld    = !v1_r || s2_ld;
  assign in_ready = s1_ld;
  assign m_valid  = v2_r;
  assign m_out    = m_r;

  // Both sides of |mz - target| * 1e7 <= target * tol, compared one stage later.
  always_comb begin
    diff = (item_r.mz >= cfg.target_mz) ? (item_r.mz - cfg.target_mz)
                                        : (cfg.target_mz - item_r.mz);
    m_nxt.mode     = item_r.mode;
    m_nxt.t        = item_r.t;
    m_nxt.inten    = item_r.inten;
    m_nxt.has_peak = item_r.has_peak;
    m_nxt.last     = item_r.last;
    m_nxt.rt_in    = (item_r.t >= cfg.rt_start) && (item_r.t <= cfg.rt_end);
    m_nxt.lhs      = {{icei_pkg::ScaleW{1'b0}}, diff}
                   * {{icei_pkg::MzW{1'b0}}, icei_pkg::TenthPpmScale};
    m_nxt.rhs      = {{icei_pkg::TolW{1'b0}}, cfg.target_mz}
                   * {{icei_pkg::MzW{1'b0}}, cfg.tolerance};
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (s1_ld) v1_r <= in_valid;
      if (s2_ld) v2_r <= v1_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (s1_ld && in_valid) item_r <= in_item;
    if (s2_ld && v1_r)     m_r    <= m_nxt;
  end

endmodule

// File: hdl/icei_track.sv
// Per-scan maximum, point emission and run maximum; holds the run state.
module icei_track (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                m_valid,
  output logic                m_ready,
  input  icei_pkg::match_t    m_in,
  output logic                p_valid,
  input  logic                p_ready,
  output icei_pkg::point_t    p_out
);

  logic                        p_valid_r;
  icei_pkg::point_t            p_r;
  icei_pkg::point_t            p_nxt;
  logic                        emit;
  logic                        take;

  logic [icei_pkg::IntW-1:0]   scan_max_r, scan_max_nxt;
  logic                        have_point_r, have_point_nxt;
  logic [icei_pkg::RtW-1:0]    prev_rt_r, prev_rt_nxt;
  logic [icei_pkg::IntW-1:0]   prev_int_r, prev_int_nxt;
  logic [icei_pkg::IntW-1:0]   best_int_r, best_int_nxt;
  logic [icei_pkg::RtW-1:0]    best_rt_r, best_rt_nxt;

  logic                        hit;
  logic                        take_best;
  logic [icei_pkg::IntW-1:0]   scan_now;
  logic [icei_pkg::RtW-1:0]    dt_raw;

  assign m_ready = !p_valid_r || p_ready;
  assign take    = m_valid && m_ready;
  assign p_valid = p_valid_r;
  assign p_out   = p_r;

  // State update for one request.
  always_comb begin
    hit       = m_in.has_peak
             && (m_in.lhs <= {{(icei_pkg::LhsW - icei_pkg::RhsW){1'b0}}, m_in.rhs});
    scan_now  = (hit && (m_in.inten > scan_max_r)) ? m_in.inten : scan_max_r;
    dt_raw    = (m_in.t >= prev_rt_r) ? (m_in.t - prev_rt_r) : '0;
    take_best = !have_point_r || (scan_now > best_int_r);

    scan_max_nxt   = scan_max_r;
    have_point_nxt = have_point_r;
    prev_rt_nxt    = prev_rt_r;
    prev_int_nxt   = prev_int_r;
    best_int_nxt   = best_int_r;
    best_rt_nxt    = best_rt_r;
    emit           = 1'b0;
    p_nxt          = '0;
    p_nxt.kind     = icei_pkg::KIND_POINT;

    if (m_in.mode) begin
      // End of run: report the run and clear it; a partial scan is dropped.
      emit           = 1'b1;
      p_nxt.kind     = icei_pkg::KIND_SUMMARY;
      p_nxt.best_int = best_int_r;
      p_nxt.best_rt  = best_rt_r;
      scan_max_nxt   = '0;
      have_point_nxt = 1'b0;
      prev_rt_nxt    = '0;
      prev_int_nxt   = '0;
      best_int_nxt   = '0;
      best_rt_nxt    = '0;
    end else if (!m_in.last) begin
      scan_max_nxt = scan_now;
    end else begin
      scan_max_nxt = '0;
      if (m_in.rt_in) begin
        // Scan closes inside the retention window: emit a point.
        emit = 1'b1;
        if (take_best) begin
          best_int_nxt = scan_now;
          best_rt_nxt  = m_in.t;
        end
        p_nxt.rt       = m_in.t;
        p_nxt.point    = scan_now;
        p_nxt.best_int = best_int_nxt;
        p_nxt.best_rt  = best_rt_nxt;
        // The first point of a run adds no area.
        p_nxt.sum      = have_point_r ? ({1'b0, scan_now} + {1'b0, prev_int_r}) : '0;
        p_nxt.dt       = have_point_r ? dt_raw : '0;
        prev_rt_nxt    = m_in.t;
        prev_int_nxt   = scan_now;
        have_point_nxt = 1'b1;
      end
    end
  end

  // Run state and output stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r    <= 1'b0;
      scan_max_r   <= '0;
      have_point_r <= 1'b0;
      prev_rt_r    <= '0;
      prev_int_r   <= '0;
      best_int_r   <= '0;
      best_rt_r    <= '0;
    end else begin
      if (m_ready) p_valid_r <= m_valid && emit;
      if (take) begin
        scan_max_r   <= scan_max_nxt;
        have_point_r <= have_point_nxt;
        prev_rt_r    <= prev_rt_nxt;
        prev_int_r   <= prev_int_nxt;
        best_int_r   <= best_int_nxt;
        best_rt_r    <= best_rt_nxt;
      end
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (take && emit) p_r <= p_nxt;
  end

endmodule

// File: hdl/icei_area.sv
// Trapezoid term multiply, saturating area accumulate and the result register.
module icei_area (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                p_valid,
  output logic                p_ready,
  input  icei_pkg::point_t    p_in,
  output logic                out_valid,
  input  logic                out_ready,
  output icei_pkg::result_t   out_res
);

  logic                          v4_r;
  logic                          vo_r;
  icei_pkg::term_t               t_r;
  icei_pkg::term_t               t_nxt;
  icei_pkg::result_t             res_r;
  icei_pkg::result_t             res_nxt;
  logic [icei_pkg::AreaW-1:0]    area_r;
  logic [icei_pkg::AreaW-1:0]    area_nxt;
  logic [icei_pkg::AreaW:0]      area_sum;
  logic                          ld4;
  logic                          ldo;

  assign ldo       = !vo_r || out_ready;
  assign ld4       = !v4_r || ldo;
  assign p_ready   = ld4;
  assign out_valid = vo_r;
  assign out_res   = res_r;

  // (I_i + I_{i-1}) * dt, registered before the accumulate.
  always_comb begin
    t_nxt.kind     = p_in.kind;
    t_nxt.rt       = p_in.rt;
    t_nxt.point    = p_in.point;
    t_nxt.best_int = p_in.best_int;
    t_nxt.best_rt  = p_in.best_rt;
    t_nxt.term     = {{icei_pkg::RtW{1'b0}}, p_in.sum} * {{icei_pkg::SumW{1'b0}}, p_in.dt};
  end

  // Saturating accumulate; a summary reports the sum and then clears it.
  always_comb begin
    area_sum = {1'b0, area_r}
             + {{(icei_pkg::AreaW + 1 - icei_pkg::TermW){1'b0}}, t_r.term};
    res_nxt.kind     = t_r.kind;
    res_nxt.rt       = t_r.rt;
    res_nxt.point    = t_r.point;
    res_nxt.best_int = t_r.best_int;
    res_nxt.best_rt  = t_r.best_rt;
    if (t_r.kind == icei_pkg::KIND_SUMMARY) begin
      res_nxt.area = area_r;
      area_nxt     = '0;
    end else begin
      res_nxt.area = area_sum[icei_pkg::AreaW] ? '1 : area_sum[icei_pkg::AreaW-1:0];
      area_nxt     = res_nxt.area;
    end
  end

  // Valid bits and the running area.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r   <= 1'b0;
      vo_r   <= 1'b0;
      area_r <= '0;
    end else begin
      if (ld4) v4_r <= p_valid;
      if (ldo) vo_r <= v4_r;
      if (ldo && v4_r) area_r <= area_nxt;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (ld4 && p_valid) t_r   <= t_nxt;
    if (ldo && v4_r)    res_r <= res_nxt;
  end

endmodule

// File: hdl/ion_chromatogram_extract_integrate.sv
// Extracted ion chromatogram with trapezoid area.
// in_ch takes one request per centroid peak (mode 0), an empty-scan marker
// (mode 0, has_peak 0) or an end-of-run request (mode 1); last_in_scan closes
// a scan. out_ch returns a chromatogram point for each scan that closes inside
// the retention window, and a run summary for each end-of-run request.
// cfg_we/cfg_index/cfg_data write the target m/z, the ppm tolerance and the
// retention window; writes belong between runs. A result passes the input
// register, window products, run state, area multiply and result register
// before it is valid on out_ch. in_ch takes one request per cycle while out_ch
// does not stall, fixed by the single update of the run state in the state stage.
// When out_ch stalls, the result register holds and the stages ahead keep
// filling their bubbles; in_ch.ready drops only once every stage is full.
// Reset clears all run state and the result stage, and returns the
// configuration to target 0, tolerance 5.0 ppm and a window of 0 to 86400000 ms.
module ion_chromatogram_extract_integrate (
  input  logic                              clk,
  input  logic                              rst_n,
  icei_in_if.sink                           in_ch,
  icei_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [icei_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [icei_pkg::CfgDataW-1:0]     cfg_data
);

  icei_pkg::cfg_t     cfg_r;
  icei_pkg::item_t    in_item;
  icei_pkg::match_t   m_pl;
  icei_pkg::point_t   p_pl;
  icei_pkg::result_t  res;
  logic               in_ready;
  logic               m_valid, m_ready;
  logic               p_valid, p_ready;
  logic               out_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_mz <= icei_pkg::TargetReset;
      cfg_r.tolerance <= icei_pkg::TolReset;
      cfg_r.rt_start  <= icei_pkg::RtStartReset;
      cfg_r.rt_end    <= icei_pkg::RtEndReset;
    end else if (cfg_we) begin
      unique case (icei_pkg::cfg_idx_t'(cfg_index))
        icei_pkg::CFG_TARGET_MZ: cfg_r.target_mz <= cfg_data[icei_pkg::MzW-1:0];
        icei_pkg::CFG_TOLERANCE: cfg_r.tolerance <= cfg_data[icei_pkg::TolW-1:0];
        icei_pkg::CFG_RT_START:  cfg_r.rt_start  <= cfg_data[icei_pkg::RtW-1:0];
        icei_pkg::CFG_RT_END:    cfg_r.rt_end    <= cfg_data[icei_pkg::RtW-1:0];
        default: ;
      endcase
    end
  end

  // Input channel unpacking.
  assign in_item.mode     = in_ch.mode;
  assign in_item.t        = in_ch.scan_time_ms;
  assign in_item.mz       = in_ch.peak_mz;
  assign in_item.inten    = in_ch.peak_intensity;
  assign in_item.has_peak = in_ch.has_peak;
  assign in_item.last     = in_ch.last_in_scan;
  assign in_ch.ready      = in_ready;

  icei_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_out    (m_pl)
  );

  icei_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_in    (m_pl),
    .p_valid (p_valid),
    .p_ready (p_ready),
    .p_out   (p_pl)
  );

  icei_area u_area (
    .clk       (clk),
    .rst_n     (rst_n),
    .p_valid   (p_valid),
    .p_ready   (p_ready),
    .p_in      (p_pl),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  // Result channel packing.
  assign out_ch.valid              = out_valid;
  assign out_ch.kind               = res.kind;
  assign out_ch.point_rt_ms        = res.rt;
  assign out_ch.point_intensity    = res.point;
  assign out_ch.peak_max_intensity = res.best_int;
  assign out_ch.peak_rt_ms         = res.best_rt;
  assign out_ch.area_scaled        = res.area;

endmodule

// File: hdl/icei_checker.sv
`include "ion_chromatogram_extract_integrate_macros.svh"

// Port-level checks on the result channel.
module icei_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [icei_pkg::RtW-1:0]    out_point_rt_ms,
  input logic [icei_pkg::IntW-1:0]   out_point_intensity,
  input logic [icei_pkg::IntW-1:0]   out_peak_max_intensity,
  input logic [icei_pkg::AreaW-1:0]  out_area_scaled
);

  // No result may be pending right after reset.
  `ICEI_ASSERT_IMP(a_idle_after_reset, $past(!rst_n), !out_valid, "result valid after reset")

  // A stalled result keeps its values.
  `ICEI_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_area_scaled) && $stable(out_point_intensity) && $stable(out_kind), "stalled result changed")

  // A summary carries no point time and no point intensity.
  `ICEI_ASSERT_IMP(a_summary_zero, out_valid && (out_kind == icei_pkg::KIND_SUMMARY), (out_point_rt_ms == '0) && (out_point_intensity == '0), "summary with point fields set")

  // A point never exceeds the run maximum reported with it.
  `ICEI_ASSERT_IMP(a_point_le_max, out_valid && (out_kind == icei_pkg::KIND_POINT), out_point_intensity <= out_peak_max_intensity, "point above run maximum")

endmodule

bind ion_chromatogram_extract_integrate icei_checker u_icei_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_ch.valid),
  .out_ready              (out_ch.ready),
  .out_kind               (out_ch.kind),
  .out_point_rt_ms        (out_ch.point_rt_ms),
  .out_point_intensity    (out_ch.point_intensity),
  .out_peak_max_intensity (out_ch.peak_max_intensity),
  .out_area_scaled        (out_ch.area_scaled)
);
